/* rtl/point_vs_segment_rect_table_hit_test_macros.svh */
// ----------------------------------------------------------------------------
// Hit test assertion macros
// Shared concurrent assertion forms for the hit test checker.
// ----------------------------------------------------------------------------
`ifndef POINT_VS_SEGMENT_RECT_TABLE_HIT_TEST_MACROS_SVH
`define POINT_VS_SEGMENT_RECT_TABLE_HIT_TEST_MACROS_SVH

// same-cycle implication
`define PVSR_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("hit test assertion failed");

// next-cycle implication
`define PVSR_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("hit test assertion failed");

`endif

/* rtl/pvsr_pkg.sv */
// ----------------------------------------------------------------------------
// Hit test package
// Sizes, codes, entry and request token types, compare helpers.
// ----------------------------------------------------------------------------
package pvsr_pkg;

	localparam int MAX_SEGMENTS   = 64;
	localparam int MAX_RECTANGLES = 32;
	localparam int COORD_W        = 11;
	localparam int IDX_W          = 6;
	localparam int SEG_CNT_W      = 7;
	localparam int RECT_CNT_W     = 6;
	localparam int CFG_W          = 7;
	localparam int SEG_REM_W      = $clog2(MAX_SEGMENTS + 1);
	localparam int RECT_REM_W     = $clog2(MAX_RECTANGLES + 1);
	localparam int PROD_W         = 2 * COORD_W + 5;
	localparam int EXT_W          = COORD_W + 2;
	localparam int TOP_BAND       = 3;
	localparam int BOTTOM_BAND    = 10;

	typedef enum logic [1:0] {
		OP_LOAD_SEG  = 2'd0,
		OP_LOAD_RECT = 2'd1,
		OP_QUERY     = 2'd2,
		OP_NONE      = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_SEG_COUNT  = 1'b0,
		REG_RECT_COUNT = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic signed [PROD_W-1:0]  wide_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} entry_t;

	typedef struct packed {
		logic                 valid;
		coord_t               px;
		coord_t               py;
		logic [SEG_REM_W-1:0] remaining;
		logic                 hit;
	} seg_tok_t;

	typedef struct packed {
		logic                  valid;
		coord_t                px;
		coord_t                py;
		logic [RECT_REM_W-1:0] remaining;
		logic                  rect;
		logic                  top;
		logic                  bot;
		logic                  found;
		coord_t                center;
	} rect_tok_t;

	function automatic logic in_range(ext_t v, ext_t a, ext_t b);
		logic lo_ok;
		logic hi_ok;
		lo_ok = (a < b) ? (v >= a) : (v >= b);
		hi_ok = (a < b) ? (v <= b) : (v <= a);
		return lo_ok && hi_ok;
	endfunction

	// trunc(n / d) == y for d > 0
	function automatic logic trunc_eq(wide_t y, wide_t yd, wide_t n, wide_t d);
		logic r;
		if (y > 0) begin
			r = (n >= yd) && (n < yd + d);
		end else if (y < 0) begin
			r = (n > yd - d) && (n <= yd);
		end else begin
			r = (n > -d) && (n < d);
		end
		return r;
	endfunction

endpackage

/* rtl/pvsr_seg_cell.sv */
// ----------------------------------------------------------------------------
// Segment cell
// Holds one platform segment and tests the passing request point against it.
// ----------------------------------------------------------------------------
module pvsr_seg_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  pvsr_pkg::entry_t   load_entry,
	input  pvsr_pkg::wide_t    load_cross,
	input  pvsr_pkg::seg_tok_t tok_in,
	output pvsr_pkg::seg_tok_t tok_out
);
	import pvsr_pkg::*;

	entry_t   ent_q;
	wide_t    cross_q;

	logic                 valid_q;
	coord_t               px_q;
	coord_t               py_q;
	logic [SEG_REM_W-1:0] rem_q;
	logic                 hit_q;

	logic signed [COORD_W:0] dy;
	logic signed [COORD_W:0] den;
	logic signed [COORD_W:0] den_abs;
	wide_t num;
	wide_t n0;
	wide_t n1;
	wide_t d_w;
	wide_t y_w;
	wide_t y_den;
	logic  box;
	logic  hit;
	logic  active;

	always_comb begin
		dy      = {ent_q.ay[COORD_W-1], ent_q.ay} - {ent_q.by[COORD_W-1], ent_q.by};
		den     = {ent_q.ax[COORD_W-1], ent_q.ax} - {ent_q.bx[COORD_W-1], ent_q.bx};
		den_abs = den[COORD_W] ? -den : den;
		num     = wide_t'(dy) * wide_t'(tok_in.px) + cross_q;
		n0      = den[COORD_W] ? -num : num;
		d_w     = wide_t'(den_abs);
		n1      = n0 + d_w;
		y_w     = wide_t'(tok_in.py);
		y_den   = y_w * d_w;
		box     = in_range(ext_t'(tok_in.px), ext_t'(ent_q.ax), ext_t'(ent_q.bx)) &&
		          in_range(ext_t'(tok_in.py), ext_t'(ent_q.ay), ext_t'(ent_q.by));
		hit     = box && (den != '0) &&
		          (trunc_eq(y_w, y_den, n0, d_w) || trunc_eq(y_w, y_den, n1, d_w));
		active  = (tok_in.remaining != '0);
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			ent_q   <= load_entry;
			cross_q <= load_cross;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		px_q  <= tok_in.px;
		py_q  <= tok_in.py;
		rem_q <= active ? tok_in.remaining - 1'b1 : tok_in.remaining;
		hit_q <= tok_in.hit | (active & hit);
	end

	assign tok_out = '{valid: valid_q, px: px_q, py: py_q, remaining: rem_q, hit: hit_q};

endmodule

/* rtl/pvsr_rect_cell.sv */
// ----------------------------------------------------------------------------
// Rectangle cell
// Holds one ladder rectangle and tests body, top band and bottom band.
// ----------------------------------------------------------------------------
module pvsr_rect_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  pvsr_pkg::entry_t    load_entry,
	input  pvsr_pkg::rect_tok_t tok_in,
	output pvsr_pkg::rect_tok_t tok_out
);
	import pvsr_pkg::*;

	entry_t    ent_q;

	logic                  valid_q;
	coord_t                px_q;
	coord_t                py_q;
	logic [RECT_REM_W-1:0] rem_q;
	logic                  rect_q;
	logic                  top_q;
	logic                  bot_q;
	logic                  found_q;
	coord_t                center_q;

	ext_t px;
	ext_t py;
	ext_t ylo;
	ext_t yhi;
	ext_t sum;
	ext_t half;
	logic x_in;
	logic body;
	logic top;
	logic bot;
	logic active;

	always_comb begin
		px     = ext_t'(tok_in.px);
		py     = ext_t'(tok_in.py);
		ylo    = (ent_q.ay < ent_q.by) ? ext_t'(ent_q.ay) : ext_t'(ent_q.by);
		yhi    = (ent_q.ay < ent_q.by) ? ext_t'(ent_q.by) : ext_t'(ent_q.ay);
		sum    = ext_t'(ent_q.ax) + ext_t'(ent_q.bx);
		half   = (sum + ext_t'(sum[EXT_W-1])) >>> 1;
		x_in   = in_range(px, ext_t'(ent_q.ax), ext_t'(ent_q.bx));
		body   = x_in && (py >= ylo) && (py <= yhi);
		top    = x_in && (py >= ylo) && (py <= ylo + ext_t'(TOP_BAND));
		bot    = x_in && (py >= yhi - ext_t'(BOTTOM_BAND)) && (py <= yhi);
		active = (tok_in.remaining != '0);
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			ent_q <= load_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		px_q     <= tok_in.px;
		py_q     <= tok_in.py;
		rem_q    <= active ? tok_in.remaining - 1'b1 : tok_in.remaining;
		rect_q   <= tok_in.rect | (active & body);
		top_q    <= tok_in.top | (active & top);
		bot_q    <= tok_in.bot | (active & bot);
		found_q  <= tok_in.found | (active & body);
		center_q <= (active && body && !tok_in.found) ? half[COORD_W-1:0]
		                                               : tok_in.center;
	end

	assign tok_out = '{valid: valid_q, px: px_q, py: py_q, remaining: rem_q,
	                   rect: rect_q, top: top_q, bot: bot_q, found: found_q,
	                   center: center_q};

endmodule

/* rtl/point_vs_segment_rect_table_hit_test.sv */
// ----------------------------------------------------------------------------
// Point vs segment/rectangle table hit test
// Two rows of cells hold the segment and rectangle tables; a query request
// walks both rows, one cell per cycle, and collects its hit flags.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_ready  | opcode, entry_index, corner_*, probe_*
//  out      | out_valid/out_ready| segment/rectangle/band hits, first_center_x
//  cfg      | cfg_we             | cfg_index, cfg_wdata
//
// A query result waits for both cell rows, so the longer segment cell row
// sets when it appears; no request is taken while a query walks the rows,
// so a new request is taken only once the last query is through. A result
// waiting at the output holds the next query's result, and with it in_ready,
// until it drains. Reset clears counts and control only.
// ----------------------------------------------------------------------------
module point_vs_segment_rect_table_hit_test (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pvsr_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [pvsr_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [pvsr_pkg::COORD_W-1:0] corner_ax,
	input  logic signed [pvsr_pkg::COORD_W-1:0] corner_ay,
	input  logic signed [pvsr_pkg::COORD_W-1:0] corner_bx,
	input  logic signed [pvsr_pkg::COORD_W-1:0] corner_by,
	input  logic signed [pvsr_pkg::COORD_W-1:0] probe_x,
	input  logic signed [pvsr_pkg::COORD_W-1:0] probe_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              segment_hit,
	output logic                              rectangle_hit,
	output logic                              top_band_hit,
	output logic                              bottom_band_hit,
	output logic signed [pvsr_pkg::COORD_W-1:0] first_center_x
);
	import pvsr_pkg::*;

	logic [SEG_CNT_W-1:0]  seg_count_q;
	logic [RECT_CNT_W-1:0] rect_count_q;
	logic                  busy_q;
	logic                  accept;
	logic                  is_query;
	logic                  is_lseg;
	logic                  is_lrect;
	logic                  finish;

	entry_t    load_entry;
	wide_t     load_cross;
	seg_tok_t  seg_chain  [MAX_SEGMENTS+1];
	rect_tok_t rect_chain [MAX_RECTANGLES+1];

	logic                  launch_valid_q;
	coord_t                launch_px_q;
	coord_t                launch_py_q;
	logic [SEG_REM_W-1:0]  seg_rem_q;
	logic [RECT_REM_W-1:0] rect_rem_q;

	logic   seg_done_q;
	logic   seg_hit_q;
	logic   rect_done_q;
	logic   rect_hit_q;
	logic   top_hit_q;
	logic   bot_hit_q;
	logic   found_q;
	coord_t center_q;

	logic   out_valid_q;
	logic   seg_out_q;
	logic   rect_out_q;
	logic   top_out_q;
	logic   bot_out_q;
	coord_t center_out_q;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign is_query = accept && (opcode_t'(opcode) == OP_QUERY);
	assign is_lseg  = accept && (opcode_t'(opcode) == OP_LOAD_SEG);
	assign is_lrect = accept && (opcode_t'(opcode) == OP_LOAD_RECT);
	assign finish   = seg_done_q && rect_done_q && (!out_valid_q || out_ready);

	assign load_entry = '{ax: corner_ax, ay: corner_ay, bx: corner_bx, by: corner_by};
	assign load_cross = wide_t'(corner_ax) * wide_t'(corner_by)
	                  - wide_t'(corner_bx) * wide_t'(corner_ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= '0;
			rect_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SEG_COUNT:  seg_count_q  <= cfg_wdata[SEG_CNT_W-1:0];
				REG_RECT_COUNT: rect_count_q <= cfg_wdata[RECT_CNT_W-1:0];
				default:        seg_count_q  <= seg_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			launch_valid_q <= 1'b0;
			seg_done_q     <= 1'b0;
			rect_done_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			launch_valid_q <= is_query;
			if (is_query) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (seg_chain[MAX_SEGMENTS].valid) begin
				seg_done_q <= 1'b1;
			end else if (finish) begin
				seg_done_q <= 1'b0;
			end
			if (rect_chain[MAX_RECTANGLES].valid) begin
				rect_done_q <= 1'b1;
			end else if (finish) begin
				rect_done_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			launch_px_q <= probe_x;
			launch_py_q <= probe_y;
			seg_rem_q   <= (32'(seg_count_q) > MAX_SEGMENTS)
			               ? SEG_REM_W'(MAX_SEGMENTS) : SEG_REM_W'(seg_count_q);
			rect_rem_q  <= (32'(rect_count_q) > MAX_RECTANGLES)
			               ? RECT_REM_W'(MAX_RECTANGLES) : RECT_REM_W'(rect_count_q);
		end
		if (seg_chain[MAX_SEGMENTS].valid) begin
			seg_hit_q <= seg_chain[MAX_SEGMENTS].hit;
		end
		if (rect_chain[MAX_RECTANGLES].valid) begin
			rect_hit_q <= rect_chain[MAX_RECTANGLES].rect;
			top_hit_q  <= rect_chain[MAX_RECTANGLES].top;
			bot_hit_q  <= rect_chain[MAX_RECTANGLES].bot;
			found_q    <= rect_chain[MAX_RECTANGLES].found;
			center_q   <= rect_chain[MAX_RECTANGLES].center;
		end
		if (finish) begin
			seg_out_q    <= seg_hit_q;
			rect_out_q   <= rect_hit_q;
			top_out_q    <= top_hit_q;
			bot_out_q    <= bot_hit_q;
			center_out_q <= found_q ? center_q : '1;
		end
	end

	assign seg_chain[0]  = '{valid: launch_valid_q, px: launch_px_q, py: launch_py_q,
	                         remaining: seg_rem_q, hit: 1'b0};
	assign rect_chain[0] = '{valid: launch_valid_q, px: launch_px_q, py: launch_py_q,
	                         remaining: rect_rem_q, rect: 1'b0, top: 1'b0, bot: 1'b0,
	                         found: 1'b0, center: '1};

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_seg
		pvsr_seg_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_en    (is_lseg && (32'(entry_index) == i)),
			.load_entry (load_entry),
			.load_cross (load_cross),
			.tok_in     (seg_chain[i]),
			.tok_out    (seg_chain[i+1])
		);
	end

	for (genvar j = 0; j < MAX_RECTANGLES; j++) begin : g_rect
		pvsr_rect_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_en    (is_lrect && (32'(entry_index) == j)),
			.load_entry (load_entry),
			.tok_in     (rect_chain[j]),
			.tok_out    (rect_chain[j+1])
		);
	end

	assign out_valid       = out_valid_q;
	assign segment_hit     = seg_out_q;
	assign rectangle_hit   = rect_out_q;
	assign top_band_hit    = top_out_q;
	assign bottom_band_hit = bot_out_q;
	assign first_center_x  = center_out_q;

endmodule

/* rtl/pvsr_chk.sv */
// ----------------------------------------------------------------------------
// Hit test port checker
// Watches the top level ports for result and request ordering rules.
// ----------------------------------------------------------------------------
`include "point_vs_segment_rect_table_hit_test_macros.svh"

module pvsr_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [1:0]                          opcode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                rectangle_hit,
	input logic signed [pvsr_pkg::COORD_W-1:0] first_center_x
);
	import pvsr_pkg::*;

	`PVSR_ASSERT_NEXT(a_query_blocks, in_valid && in_ready && (opcode_t'(opcode) == OP_QUERY), !in_ready)
	`PVSR_ASSERT_NOW(a_center_none, out_valid && !rectangle_hit, first_center_x == '1)
	`PVSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PVSR_ASSERT_NEXT(a_center_hold, out_valid && !out_ready, $stable(first_center_x))

endmodule

bind point_vs_segment_rect_table_hit_test pvsr_chk u_pvsr_chk (.*);
